[hw/rtl/cosine_template_classifier_defines.svh]
// assertion macros shared by the checker of the cosine template classifier
// no dependencies; included by files that hold concurrent assertions
`ifndef COSINE_TEMPLATE_CLASSIFIER_DEFINES_SVH
`define COSINE_TEMPLATE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CTC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctc assertion failed");

// next-cycle implication, disabled during reset
`define CTC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctc assertion failed");

`endif

[hw/rtl/ctc_pkg.sv]
// shared types, constants and helpers of the cosine template classifier
// no dependencies; used by ctc_ctrl, ctc_dp, the top level and the checker
package ctc_pkg;

   // fixed field and accumulator widths
   localparam int ACC_W   = 24;
   localparam int CSR_W   = 9;
   localparam int CLASS_W = 4;
   localparam int TIDX_W  = 4;
   localparam int PIDX_W  = 8;
   localparam int PVAL_W  = 8;

   localparam logic [CSR_W-1:0] PIXELS_IN_USE_RESET = 9'd196;

   // request opcodes
   localparam logic OPC_LOAD  = 1'b0;
   localparam logic OPC_IMAGE = 1'b1;

   // classification step of the datapath; the SQ, L and R steps use its shared multiplier
   typedef enum logic [2:0] {
      OP_NONE,
      OP_SQ,
      OP_L0,
      OP_L1,
      OP_R0,
      OP_R1,
      OP_CMP,
      OP_TAKE
   } cl_op_type;

   // commands from controller to datapath
   typedef struct packed {
      logic      accept;
      logic      mac_rd;
      logic      energy_en;
      logic      cl_init;
      cl_op_type op;
      logic      publish;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic in_range;
      logic blank;
      logic pair_zero;
   } dp_status_type;

   // add that sticks at all ones on overflow
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [ACC_W-1:0] addend);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {1'b0, addend};
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

endpackage

[hw/rtl/ctc_ctrl.sv]
// controller of the cosine template classifier: handshakes and step sequencing
// depends on ctc_pkg; drives ctc_dp through command and status structs
module ctc_ctrl #(
   parameter int NUM_TEMPLATES = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic                                req_last_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  ctc_pkg::dp_status_type              status,
   output ctc_pkg::dp_cmd_type                 cmd,
   output logic [$clog2(NUM_TEMPLATES+1)-1:0]  tpl_cnt
);

   localparam int CNT_W = $clog2(NUM_TEMPLATES + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_CHECK,
      ST_SQ,
      ST_TAKE,
      ST_L0,
      ST_L1,
      ST_R0,
      ST_R1,
      ST_CMP,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             have_ff, have_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             cnt_end;

   // a word is taken only while nothing is in flight
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign cnt_end   = (cnt_ff == CNT_W'(NUM_TEMPLATES));
   assign tpl_cnt   = cnt_ff;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      have_in       = have_ff;
      cmd           = '0;
      cmd.op        = ctc_pkg::OP_NONE;
      cmd.accept    = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == ctc_pkg::OPC_IMAGE)) begin
               last_in = req_last_pixel;
               cnt_in  = '0;
               if (status.in_range) begin
                  state_in = ST_MAC;
               end else if (req_last_pixel) begin
                  state_in    = ST_CHECK;
                  cmd.cl_init = 1'b1;
                  have_in     = 1'b0;
               end
            end
         end
         ST_MAC: begin
            // one template read per cycle, accumulated in the cycle after its read
            cmd.mac_rd    = (cnt_ff < CNT_W'(NUM_TEMPLATES));
            cmd.energy_en = (cnt_ff == '0);
            if (cnt_end) begin
               cnt_in = '0;
               if (last_ff) begin
                  state_in    = ST_CHECK;
                  cmd.cl_init = 1'b1;
                  have_in     = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.blank || cnt_end) begin
               state_in = ST_FINISH;
            end else if (status.pair_zero) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.op   = ctc_pkg::OP_SQ;
            state_in = have_ff ? ST_L0 : ST_TAKE;
         end
         ST_TAKE: begin
            cmd.op   = ctc_pkg::OP_TAKE;
            have_in  = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_L0: begin
            cmd.op   = ctc_pkg::OP_L0;
            state_in = ST_L1;
         end
         ST_L1: begin
            cmd.op   = ctc_pkg::OP_L1;
            state_in = ST_R0;
         end
         ST_R0: begin
            cmd.op   = ctc_pkg::OP_R0;
            state_in = ST_R1;
         end
         ST_R1: begin
            cmd.op   = ctc_pkg::OP_R1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.op   = ctc_pkg::OP_CMP;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.publish;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/ctc_dp.sv]
// datapath of the cosine template classifier: template memory, accumulators,
// shared 24x24 multiplier for the cross-multiplied compare; depends on ctc_pkg
module ctc_dp #(
   parameter int NUM_TEMPLATES = 9,
   parameter int MAX_PIXELS    = 256,
   parameter int PIXEL_BITS    = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ctc_pkg::dp_cmd_type                       cmd,
   input  logic [$clog2(NUM_TEMPLATES+1)-1:0]        tpl_cnt,
   input  logic                                      req_opcode,
   input  logic [ctc_pkg::TIDX_W-1:0]                req_template_index,
   input  logic [ctc_pkg::PIDX_W-1:0]                req_pixel_index,
   input  logic [ctc_pkg::PVAL_W-1:0]                req_pixel_value,
   input  logic                                      csr_wr_en,
   input  logic [ctc_pkg::CSR_W-1:0]                 csr_wr_data,
   output ctc_pkg::dp_status_type                    status,
   output logic [ctc_pkg::CLASS_W-1:0]               rsp_class_index,
   output logic                                      rsp_blank_image
);

   localparam int CNT_W  = $clog2(NUM_TEMPLATES + 1);
   localparam int IDX_W  = $clog2(NUM_TEMPLATES);
   localparam int DEPTH  = NUM_TEMPLATES * MAX_PIXELS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PROD_W = 2 * PIXEL_BITS;
   localparam int ACC_W  = ctc_pkg::ACC_W;
   localparam int SQ_W   = 2 * ctc_pkg::ACC_W;
   localparam int WIDE_W = 3 * ctc_pkg::ACC_W;

   // template store, undefined until written
   logic [PIXEL_BITS-1:0]      tpl_mem [DEPTH];

   logic [ctc_pkg::CSR_W-1:0]  pixels_in_use_ff;
   logic [ctc_pkg::PIDX_W-1:0] pidx_ff;
   logic [PIXEL_BITS-1:0]      pix_ff, pix_in;
   logic [PIXEL_BITS-1:0]      mem_q_ff;
   logic                       rd_vld_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic [ACC_W-1:0]           dot_ff [NUM_TEMPLATES];
   logic [ACC_W-1:0]           en_ff  [NUM_TEMPLATES];
   logic [ACC_W-1:0]           dot_in, en_in;
   logic [ACC_W-1:0]           img_en_ff, img_en_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [SQ_W-1:0]            prod_ff;
   logic [WIDE_W-1:0]          lhs_ff, lhs_in;
   logic [WIDE_W-1:0]          rhs_ff, rhs_in;
   logic [WIDE_W-1:0]          rhs_total;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic [SQ_W-1:0]            best_sq_ff, best_sq_in;
   logic [ACC_W-1:0]           best_en_ff, best_en_in;
   logic [ctc_pkg::CLASS_W-1:0] class_ff;
   logic                       blank_ff;
   logic                       load_we;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [IDX_W-1:0]           cl_idx;
   logic                       cl_valid;
   logic [ACC_W-1:0]           cur_dot, cur_en;
   logic [ACC_W-1:0]           mul_a, mul_b;
   logic [SQ_W-1:0]            mul_p;
   logic                       take;

   assign pix_in = PIXEL_BITS'(req_pixel_value);

   // template load decode and addressing
   assign load_we = cmd.accept && (req_opcode == ctc_pkg::OPC_LOAD)
                    && ({28'd0, req_template_index} < NUM_TEMPLATES)
                    && ({24'd0, req_pixel_index} < MAX_PIXELS);
   assign wr_addr = ADDR_W'({28'd0, req_template_index} * MAX_PIXELS
                            + {24'd0, req_pixel_index});
   assign rd_addr = ADDR_W'(32'(tpl_cnt[IDX_W-1:0]) * MAX_PIXELS + 32'(pidx_ff));

   // status back to the controller
   assign cl_idx    = tpl_cnt[IDX_W-1:0];
   assign cl_valid  = (tpl_cnt < CNT_W'(NUM_TEMPLATES));
   assign cur_dot   = cl_valid ? dot_ff[cl_idx] : '0;
   assign cur_en    = cl_valid ? en_ff[cl_idx] : '0;
   assign status.in_range  = ({1'b0, req_pixel_index} < pixels_in_use_ff)
                             && ({24'd0, req_pixel_index} < MAX_PIXELS);
   assign status.blank     = (img_en_ff == '0);
   assign status.pair_zero = (cur_dot == '0) || (cur_en == '0);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_in_use_ff <= ctc_pkg::PIXELS_IN_USE_RESET;
      end else if (csr_wr_en) begin
         pixels_in_use_ff <= csr_wr_data;
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pidx_ff <= req_pixel_index;
         pix_ff  <= pix_in;
      end
   end

   // template memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (load_we) begin
         tpl_mem[wr_addr] <= pix_in;
      end
      if (cmd.mac_rd) begin
         mem_q_ff <= tpl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.mac_rd;
      end
      rd_idx_ff <= tpl_cnt[IDX_W-1:0];
   end

   // per-template dot and energy terms
   assign dot_in = ctc_pkg::sat_add(dot_ff[rd_idx_ff],
                      ACC_W'(PROD_W'(pix_ff) * PROD_W'(mem_q_ff)));
   assign en_in  = ctc_pkg::sat_add(en_ff[rd_idx_ff],
                      ACC_W'(PROD_W'(mem_q_ff) * PROD_W'(mem_q_ff)));
   assign img_en_in = ctc_pkg::sat_add(img_en_ff,
                         ACC_W'(PROD_W'(pix_ff) * PROD_W'(pix_ff)));

   // accumulators, cleared on reset and when a result is published
   always_ff @(posedge clock) begin
      if (reset || cmd.publish) begin
         for (int i = 0; i < NUM_TEMPLATES; i++) begin
            dot_ff[i] <= '0;
            en_ff[i]  <= '0;
         end
         img_en_ff <= '0;
      end else begin
         if (rd_vld_ff) begin
            dot_ff[rd_idx_ff] <= dot_in;
            en_ff[rd_idx_ff]  <= en_in;
         end
         if (cmd.energy_en) begin
            img_en_ff <= img_en_in;
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.op)
         ctc_pkg::OP_SQ: begin
            mul_a = cur_dot;
            mul_b = cur_dot;
         end
         ctc_pkg::OP_L0: begin
            mul_a = sq_ff[ACC_W-1:0];
            mul_b = best_en_ff;
         end
         ctc_pkg::OP_L1: begin
            mul_a = sq_ff[SQ_W-1:ACC_W];
            mul_b = best_en_ff;
         end
         ctc_pkg::OP_R0: begin
            mul_a = best_sq_ff[ACC_W-1:0];
            mul_b = cur_en;
         end
         ctc_pkg::OP_R1: begin
            mul_a = best_sq_ff[SQ_W-1:ACC_W];
            mul_b = cur_en;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_b);

   // cross products built from two partial products each
   assign rhs_total = rhs_ff + (WIDE_W'(prod_ff) << ACC_W);

   always_comb begin
      sq_in       = sq_ff;
      lhs_in      = lhs_ff;
      rhs_in      = rhs_ff;
      best_idx_in = best_idx_ff;
      best_sq_in  = best_sq_ff;
      best_en_in  = best_en_ff;
      take        = 1'b0;
      case (cmd.op)
         ctc_pkg::OP_SQ:   sq_in  = mul_p;
         ctc_pkg::OP_L1:   lhs_in = WIDE_W'(prod_ff);
         ctc_pkg::OP_R0:   lhs_in = lhs_ff + (WIDE_W'(prod_ff) << ACC_W);
         ctc_pkg::OP_R1:   rhs_in = WIDE_W'(prod_ff);
         ctc_pkg::OP_CMP:  take   = (lhs_ff > rhs_total);
         ctc_pkg::OP_TAKE: take   = 1'b1;
         default: begin
         end
      endcase
      // strictly greater keeps the lower index on ties
      if (take) begin
         best_idx_in = cl_idx;
         best_sq_in  = sq_ff;
         best_en_in  = cur_en;
      end
      if (cmd.cl_init) begin
         best_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      prod_ff     <= mul_p;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      best_idx_ff <= best_idx_in;
      best_sq_ff  <= best_sq_in;
      best_en_ff  <= best_en_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         class_ff <= ctc_pkg::CLASS_W'(best_idx_ff);
         blank_ff <= (img_en_ff == '0);
      end
   end

   assign rsp_class_index = class_ff;
   assign rsp_blank_image = blank_ff;

endmodule

[hw/rtl/cosine_template_classifier.sv]
// top level of the cosine template classifier: controller plus datapath
// depends on ctc_pkg, ctc_ctrl and ctc_dp
//
//   channel | direction | handshake           | fields
//   req     | in        | req_valid/req_stall | opcode, template_index, pixel_index,
//           |           |                     | pixel_value, last_pixel
//   rsp     | out       | rsp_valid/rsp_stall | class_index, blank_image
//   csr     | in        | csr_wr_en           | csr_wr_data (pixels in use)
//
// a template load is taken without leaving idle; an image pixel in range makes
// one template read per cycle from the single template memory port
// a last pixel adds the exact compare per template through one shared 24x24
// multiplier (check, square, then take or four partial products and compare), plus
// the scan close and result load; a blank image skips the per-template compare
// reset is synchronous and active high; accumulators clear, templates do not
// a stalled result holds in the output register while further words are taken;
// the next last pixel then waits and holds off the input
module cosine_template_classifier #(
   parameter int NUM_TEMPLATES = 9,
   parameter int MAX_PIXELS    = 256,
   parameter int PIXEL_BITS    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [ctc_pkg::TIDX_W-1:0]   req_template_index,
   input  logic [ctc_pkg::PIDX_W-1:0]   req_pixel_index,
   input  logic [ctc_pkg::PVAL_W-1:0]   req_pixel_value,
   input  logic                         req_last_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ctc_pkg::CLASS_W-1:0]  rsp_class_index,
   output logic                         rsp_blank_image,
   input  logic                         csr_wr_en,
   input  logic [ctc_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int CNT_W = $clog2(NUM_TEMPLATES + 1);

   ctc_pkg::dp_cmd_type    cmd;
   ctc_pkg::dp_status_type status;
   logic [CNT_W-1:0]       tpl_cnt;

   // sequencing and handshakes
   ctc_ctrl #(
      .NUM_TEMPLATES (NUM_TEMPLATES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd),
      .tpl_cnt        (tpl_cnt)
   );

   // storage and arithmetic
   ctc_dp #(
      .NUM_TEMPLATES (NUM_TEMPLATES),
      .MAX_PIXELS    (MAX_PIXELS),
      .PIXEL_BITS    (PIXEL_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .tpl_cnt            (tpl_cnt),
      .req_opcode         (req_opcode),
      .req_template_index (req_template_index),
      .req_pixel_index    (req_pixel_index),
      .req_pixel_value    (req_pixel_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .status             (status),
      .rsp_class_index    (rsp_class_index),
      .rsp_blank_image    (rsp_blank_image)
   );

endmodule

[hw/rtl/ctc_checker.sv]
// port-level assertions for the cosine template classifier, bound to the top
// depends on ctc_pkg and cosine_template_classifier_defines.svh
`include "cosine_template_classifier_defines.svh"

module ctc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_opcode,
   input logic                         req_last_pixel,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ctc_pkg::CLASS_W-1:0]  rsp_class_index,
   input logic                         rsp_blank_image
);

   // a stalled result word holds
   `CTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_class_index) && $stable(rsp_blank_image))

   // a last image word always keeps the block busy for the next cycle
   `CTC_ASSERT_NEXT(a_image_busy, clock, reset, req_valid && !req_stall && (req_opcode == ctc_pkg::OPC_IMAGE) && req_last_pixel, req_stall)

   // a template load leaves the block free to take a word in the next cycle
   `CTC_ASSERT_NEXT(a_load_single, clock, reset, req_valid && !req_stall && (req_opcode == ctc_pkg::OPC_LOAD), !req_stall)

   // a blank image reports class zero
   `CTC_ASSERT_IMPL(a_blank_class, clock, reset, rsp_valid && rsp_blank_image, rsp_class_index == '0)

   // a new result only appears at the end of busy work
   `CTC_ASSERT_IMPL(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind cosine_template_classifier ctc_checker u_ctc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_opcode      (req_opcode),
   .req_last_pixel  (req_last_pixel),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_class_index (rsp_class_index),
   .rsp_blank_image (rsp_blank_image)
);

[test/cosine_template_classifier_test.sv]
// self-checking testbench of the cosine template classifier: templates and image words in,
// best-match class out, every result checked against an in-bench classifier
// depends on ctc_pkg and cosine_template_classifier
module cosine_template_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TPL        = 9;
   localparam int MAX_PIX        = 256;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 150;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int NUM_PHASES     = 8;
   localparam int WORDS_PER_PHASE = 55;
   localparam int HOLD_AT_RESULT = 10;
   localparam int HOLD_CYCLES    = 1500;
   localparam int SAT_PIXELS     = 270;
   localparam longint unsigned ACC_LIMIT = (64'd1 << ctc_pkg::ACC_W) - 1;

   typedef struct packed {
      logic                       opcode;
      logic [ctc_pkg::TIDX_W-1:0] tidx;
      logic [ctc_pkg::PIDX_W-1:0] pidx;
      logic [ctc_pkg::PVAL_W-1:0] value;
      logic                       last;
   } pixel_word_type;

   typedef struct packed {
      logic [ctc_pkg::CLASS_W-1:0] class_idx;
      logic                        blank;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = ctc_pkg::OPC_LOAD;
   logic [ctc_pkg::TIDX_W-1:0] req_template_index = '0;
   logic [ctc_pkg::PIDX_W-1:0] req_pixel_index = '0;
   logic [ctc_pkg::PVAL_W-1:0] req_pixel_value = '0;
   logic req_last_pixel = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ctc_pkg::CLASS_W-1:0] rsp_class_index;
   logic rsp_blank_image;
   logic csr_wr_en = 1'b0;
   logic [ctc_pkg::CSR_W-1:0] csr_wr_data = '0;

   cosine_template_classifier #(
      .NUM_TEMPLATES(NUM_TPL),
      .MAX_PIXELS(MAX_PIX),
      .PIXEL_BITS(ctc_pkg::PVAL_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_template_index(req_template_index),
      .req_pixel_index(req_pixel_index),
      .req_pixel_value(req_pixel_value),
      .req_last_pixel(req_last_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_class_index(rsp_class_index),
      .rsp_blank_image(rsp_blank_image),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // words waiting to be offered, and class verdicts waiting to come out
   pixel_word_type words_to_send[$];
   verdict_type    verdicts_due[$];
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   // handshake history, registered at the rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   // idling style of the current phase
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   // classifier copy: template memory, running sums and pixel window
   logic [ctc_pkg::PVAL_W-1:0] tmpl_mem [NUM_TPL][MAX_PIX];
   logic [ctc_pkg::ACC_W-1:0]  dot_acc [NUM_TPL];
   logic [ctc_pkg::ACC_W-1:0]  egy_acc [NUM_TPL];
   logic [ctc_pkg::ACC_W-1:0]  img_egy;
   logic [ctc_pkg::CSR_W-1:0]  pix_limit;

   // which template entries the stimulus has written so far
   bit loaded_at [NUM_TPL][MAX_PIX];
   int gen_limit = int'(ctc_pkg::PIXELS_IN_USE_RESET);

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic int unsigned draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // saturating accumulate
   function automatic logic [ctc_pkg::ACC_W-1:0] acc_add(
         input logic [ctc_pkg::ACC_W-1:0] acc, input int unsigned addend);
      longint unsigned total;
      total = 64'(acc) + 64'(addend);
      return (total > ACC_LIMIT) ? ACC_LIMIT[ctc_pkg::ACC_W-1:0]
                                 : total[ctc_pkg::ACC_W-1:0];
   endfunction

   function automatic void clear_sums();
      for (int i = 0; i < NUM_TPL; i++) begin
         dot_acc[i] = '0;
         egy_acc[i] = '0;
      end
      img_egy = '0;
   endfunction

   // apply one accepted word to the classifier copy, queueing a verdict on a last pixel
   function automatic void absorb_word(input pixel_word_type w);
      int unsigned pv, tv, best;
      bit have;
      logic [71:0] d_new, e_new, d_best, e_best;
      verdict_type v;
      if (w.opcode == ctc_pkg::OPC_LOAD) begin
         if (32'(w.tidx) < NUM_TPL) tmpl_mem[w.tidx][w.pidx] = w.value;
         return;
      end
      pv = 32'(w.value);
      if ({1'b0, w.pidx} < pix_limit) begin
         img_egy = acc_add(img_egy, pv * pv);
         for (int i = 0; i < NUM_TPL; i++) begin
            tv = 32'(tmpl_mem[i][w.pidx]);
            dot_acc[i] = acc_add(dot_acc[i], pv * tv);
            egy_acc[i] = acc_add(egy_acc[i], tv * tv);
         end
      end
      if (!w.last) return;
      best = 0;
      have = 1'b0;
      v.blank = (img_egy == '0);
      // exact cosine compare: dot_i^2 * E_best against dot_best^2 * E_i
      if (!v.blank) begin
         for (int i = 0; i < NUM_TPL; i++) begin
            if (dot_acc[i] != '0 && egy_acc[i] != '0) begin
               if (!have) begin
                  best = i;
                  have = 1'b1;
               end else begin
                  d_new  = 72'(dot_acc[i]);
                  e_new  = 72'(egy_acc[i]);
                  d_best = 72'(dot_acc[best]);
                  e_best = 72'(egy_acc[best]);
                  if (d_new * d_new * e_best > d_best * d_best * e_new) best = i;
               end
            end
         end
      end
      v.class_idx = best[ctc_pkg::CLASS_W-1:0];
      verdicts_due.insert(verdicts_due.size(), v);
      clear_sums();
   endfunction

   // sampling at the rising edge: check results, then predict from accepted words
   always @(posedge clock) begin
      pixel_word_type w;
      verdict_type got, want;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         pix_limit = ctc_pkg::PIXELS_IN_USE_RESET;
         clear_sums();
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            got.class_idx = rsp_class_index;
            got.blank = rsp_blank_image;
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result class %0d blank %0b",
                                         got.class_idx, got.blank));
            end else begin
               want = verdicts_due.pop_front();
               if (got.class_idx !== want.class_idx)
                  report_mismatch($sformatf("class_index %0d, expected %0d",
                                            got.class_idx, want.class_idx));
               if (got.blank !== want.blank)
                  report_mismatch($sformatf("blank_image %0b, expected %0b",
                                            got.blank, want.blank));
            end
         end
         if (req_valid && !req_stall) begin
            w = {req_opcode, req_template_index, req_pixel_index, req_pixel_value,
                 req_last_pixel};
            words_taken++;
            absorb_word(w);
         end
         if (csr_wr_en) pix_limit = csr_wr_data;
      end
   end

   // request driver: one word at a time from the pending queue, random gaps
   pixel_word_type cur_word = '0;
   bit offering = 1'b0;
   int unsigned tx_gap = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (offering && req_fire) begin
            offering = 1'b0;
            tx_gap = draw_wait(tx_calm);
         end
         if (!offering) begin
            if (tx_gap != 0) tx_gap--;
            else if (words_to_send.size() != 0) begin
               cur_word = words_to_send.pop_front();
               offering = 1'b1;
            end
         end
         req_valid <= offering;
         req_opcode <= cur_word.opcode;
         req_template_index <= cur_word.tidx;
         req_pixel_index <= cur_word.pidx;
         req_pixel_value <= cur_word.value;
         req_last_pixel <= cur_word.last;
      end
   end

   // result receiver: random stall per word, one long hold-off to back the block up
   int unsigned rx_wait = 0;
   int unsigned rx_hold = 0;
   int unsigned results_taken = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            results_taken++;
            rx_wait = draw_wait(rx_calm);
            if (results_taken == HOLD_AT_RESULT) rx_hold = HOLD_CYCLES;
         end
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_wait != 0 && rsp_valid) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus helpers
   task automatic push_load(input int tidx, input int pidx, input int value, input bit last);
      pixel_word_type w;
      w.opcode = ctc_pkg::OPC_LOAD;
      w.tidx = tidx[ctc_pkg::TIDX_W-1:0];
      w.pidx = pidx[ctc_pkg::PIDX_W-1:0];
      w.value = value[ctc_pkg::PVAL_W-1:0];
      w.last = last;
      if (tidx < NUM_TPL) loaded_at[tidx][pidx] = 1'b1;
      words_to_send.insert(words_to_send.size(), w);
      words_queued++;
   endtask

   task automatic push_pixel(input int pidx, input int value, input bit last);
      pixel_word_type w;
      w.opcode = ctc_pkg::OPC_IMAGE;
      w.tidx = ctc_pkg::TIDX_W'($urandom_range(0, 15));
      w.pidx = pidx[ctc_pkg::PIDX_W-1:0];
      w.value = value[ctc_pkg::PVAL_W-1:0];
      w.last = last;
      words_to_send.insert(words_to_send.size(), w);
      words_queued++;
   endtask

   // intensities biased towards black and full white
   function automatic int pick_level();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 0;
      if (r == 2) return 255;
      return $urandom_range(0, 255);
   endfunction

   task automatic wait_idle();
      while (words_taken != words_queued || verdicts_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int pos0[NUM_TPL];
      int pos1[NUM_TPL];
      int lim, span, start, n, pidx, val;
      bit dark;

      pos0 = '{0, 0, 7, 14, 7, 0, 14, 0, 3};
      pos1 = '{0, 5, 1, 2, 1, 0, 2, 0, 255};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: scaled and identical templates tie, zero templates never win
      for (int t = 0; t < NUM_TPL; t++) begin
         push_load(t, 0, pos0[t], 1'b0);
         push_load(t, 1, pos1[t], t == NUM_TPL - 1);
      end
      push_pixel(0, 255, 1'b0);
      push_pixel(1, 0, 1'b1);
      // blank images, one of them from a pixel beyond the window, then one that classifies
      push_pixel(0, 0, 1'b1);
      push_pixel(200, 255, 1'b1);
      push_pixel(1, 255, 1'b1);
      // loads to absent templates are dropped
      push_load(9, 3, 255, 1'b0);
      push_load(15, 255, 0, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            case (p)
               1: lim = 1;
               2: lim = 0;
               3: lim = 256;
               4: lim = 511;
               5: lim = 16;
               6: lim = 255;
               default: lim = $urandom_range(2, 64);
            endcase
            csr_wr_en <= 1'b1;
            csr_wr_data <= lim[ctc_pkg::CSR_W-1:0];
            @(negedge clock);
            csr_wr_en <= 1'b0;
            @(posedge clock);
            gen_limit = lim;
         end
         tx_calm = (p % 3 == 1);
         rx_calm = (p % 4 == 2);
         span = (gen_limit > MAX_PIX) ? MAX_PIX : gen_limit;

         // one very long bright image saturates the image energy and the full-white template sums
         if (gen_limit == 256) begin
            for (int t = 0; t < NUM_TPL; t++)
               push_load(t, 0, (t == 4 || t == 7) ? 255 : $urandom_range(0, 255), 1'b0);
            for (int k = 0; k < SAT_PIXELS; k++) push_pixel(0, 255, k == SAT_PIXELS - 1);
         end

         // random images, missing templates loaded just before they are read
         start = words_queued;
         while (words_queued - start < WORDS_PER_PHASE) begin
            n = $urandom_range(1, 12);
            dark = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 99) < 8)
                  push_load($urandom_range(0, 15), $urandom_range(0, 255),
                            $urandom_range(0, 255), 1'($urandom_range(0, 1)));
               if (span != 0 && $urandom_range(0, 99) < 85) pidx = $urandom_range(0, span - 1);
               else pidx = $urandom_range(0, 255);
               if (pidx < gen_limit) begin
                  for (int t = 0; t < NUM_TPL; t++)
                     if (!loaded_at[t][pidx])
                        push_load(t, pidx, pick_level(), 1'($urandom_range(0, 1)));
               end
               val = dark ? 0 : pick_level();
               push_pixel(pidx, val, k == n - 1);
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
